### design/cmdp_pkg.sv
// Shared constants, codes and command/status types for the cache diagnostic port.
package cmdp_pkg;

    localparam int STORE_BYTES = 65536;
    localparam int LINE_BYTES  = 8;

    localparam int ADDR_W     = $clog2(STORE_BYTES);
    localparam int LINE_SH    = $clog2(LINE_BYTES);
    localparam int LINE_COUNT = STORE_BYTES / LINE_BYTES;
    localparam int LINE_W     = ADDR_W - LINE_SH;

    // valid bits are kept 32 to a row so the clear sweep goes a row per cycle
    localparam int VROW_BITS = 32;
    localparam int VROW_SH   = $clog2(VROW_BITS);
    localparam int VROWS     = LINE_COUNT / VROW_BITS;
    localparam int VROW_W    = $clog2(VROWS);

    localparam int NBANK      = 4;
    localparam int BANK_DEPTH = STORE_BYTES / NBANK;

    localparam logic [1:0] KIND_CACHE_RD = 2'd0;
    localparam logic [1:0] KIND_STORE_WR = 2'd1;
    localparam logic [1:0] KIND_REG_RD   = 2'd2;
    localparam logic [1:0] KIND_REG_WR   = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    localparam logic [15:0] REG_SPLIT = 16'd0;
    localparam logic [15:0] REG_CTRL  = 16'd1;
    localparam logic [15:0] REG_DIAG  = 16'd2;

    localparam logic [7:0] CTRL_RESET     = 8'h02;
    localparam logic [7:0] DIAG_MISS      = 8'h80;
    localparam logic [7:0] DIAG_WR_MASK   = 8'h77;
    localparam logic [7:0] DIAG_MODE_MASK = 8'h21;
    localparam logic [7:0] DIAG_MODE_WIN  = 8'h20;
    localparam logic [7:0] DIAG_MODE_CLR  = 8'h01;
    localparam logic [7:0] CTRL_WIN_EN    = 8'h10;
    localparam logic [7:0] REG_UNKNOWN    = 8'hFF;

    typedef struct packed {
        logic accept;
        logic exec;
        logic clear_step;
    } cmd_t;

    typedef struct packed {
        logic clear_req;
        logic clear_done;
    } sts_t;

endpackage

### design/cache_miss_diagnostic_port.sv
// Top level of the cache diagnostic port: controller plus datapath.
//
// Input channel (in_valid/in_ready) carries one access word: kind, address,
// access_size, write_data. Output channel (out_valid/out_ready) returns one
// result word per access: read_data, window_active, rom_timing.
// An access is accepted in one cycle and executed in the next, when the data
// banks and the valid-bit row read at accept time are available; the result
// register loads at that edge. No new access is accepted until the last one
// has executed.
// A write to the diagnostic register that switches it into the clear mode
// starts a sweep of the valid memory, one 32-line row per cycle, 256 rows
// with the default store size. Reset starts the same sweep; no access is
// accepted until it ends. Store contents are not reset.
// A stalled receiver holds the result word and in_ready stays low until that
// word is taken; the next access can be accepted in the same cycle.
module cache_miss_diagnostic_port (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] address,
    input  logic [1:0]  access_size,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        window_active,
    output logic        rom_timing
);
    import cmdp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cmdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cmdp_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .address       (address),
        .access_size   (access_size),
        .write_data    (write_data),
        .read_data     (read_data),
        .window_active (window_active),
        .rom_timing    (rom_timing)
    );

endmodule

### design/cmdp_ctrl.sv
// Controller: accept / execute / valid-clear sequencing and output handshake.
module cmdp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  cmdp_pkg::sts_t sts,
    output cmdp_pkg::cmd_t cmd
);
    import cmdp_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign out_valid = out_valid_reg;

    assign cmd.accept     = in_valid && in_ready;
    assign cmd.exec       = (state_reg == ST_EXEC) && slot_free;
    assign cmd.clear_step = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (cmd.exec)
                    state_next = sts.clear_req ? ST_CLEAR : ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == ST_EXEC)
        else $error("accepted word did not enter execute");

    a_exec_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && !sts.clear_req |=> state_reg == ST_IDLE && out_valid_reg)
        else $error("executed word not presented");

    a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR && !sts.clear_done |=> state_reg == ST_CLEAR && !in_ready)
        else $error("valid clear sweep cut short");

    a_stall_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC && out_valid_reg && !out_ready |=> state_reg == ST_EXEC)
        else $error("execute overran a stalled output");

endmodule

### design/cmdp_datapath.sv
// Datapath: banked data store, valid-bit memory, control registers, result registers.
module cmdp_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  cmdp_pkg::cmd_t cmd,
    output cmdp_pkg::sts_t sts,
    input  logic [1:0]     kind,
    input  logic [15:0]    address,
    input  logic [1:0]     access_size,
    input  logic [7:0]     write_data,
    output logic [31:0]    read_data,
    output logic           window_active,
    output logic           rom_timing
);
    import cmdp_pkg::*;

    logic [1:0]  kind_reg;
    logic [15:0] addr_reg;
    logic [1:0]  size_reg;
    logic [7:0]  data_reg;

    logic [7:0] split_reg, split_next;
    logic [7:0] ctrl_reg, ctrl_next;
    logic [7:0] diag_reg, diag_next;
    logic       pend_reg, pend_next;
    logic [VROW_W-1:0] clr_ptr_reg;

    logic [31:0] read_data_reg;
    logic        window_reg;
    logic        rom_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] base;
    logic [7:0]        bank_q [NBANK];
    logic              bank_we;

    logic [LINE_W-1:0]    rd_line, cur_line;
    logic [VROW_BITS-1:0] vmem [VROWS];
    logic [VROW_BITS-1:0] vq_reg;
    logic [VROW_W-1:0]    cur_row;
    logic [VROW_SH-1:0]   cur_bit;
    logic                 line_hit;
    logic                 miss_wr;

    logic [31:0] rd_bytes;
    logic [31:0] rd_val;
    logic [7:0]  wr_mode;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= kind;
            addr_reg <= address;
            size_reg <= access_size;
            data_reg <= write_data;
        end
    end

    // memories are read every cycle at the held item so the read data stays put while stalled
    assign rd_addr = cmd.accept ? address[ADDR_W-1:0] : addr_reg[ADDR_W-1:0];
    assign base    = addr_reg[ADDR_W-1:0];
    assign bank_we = cmd.exec && (kind_reg == KIND_STORE_WR);

    for (genvar b = 0; b < NBANK; b++)
    begin : g_bank
        logic [7:0]        mem [BANK_DEPTH];
        logic [7:0]        q_reg;
        logic [1:0]        offs;
        logic [ADDR_W-1:0] rd_a;

        // the byte of a 4-byte span that falls in this bank; wraps at the store end
        assign offs = 2'(b) - rd_addr[1:0];
        assign rd_a = rd_addr + ADDR_W'(offs);

        always_ff @(posedge clk)
        begin
            if (bank_we && (base[1:0] == 2'(b)))
                mem[base[ADDR_W-1:2]] <= data_reg;
            q_reg <= mem[rd_a[ADDR_W-1:2]];
        end

        assign bank_q[b] = q_reg;
    end

    always_comb
    begin
        rd_bytes = '0;
        for (int i = 0; i < NBANK; i++)
        begin
            rd_bytes[8*i +: 8] = bank_q[base[1:0] + 2'(i)];
        end
        if (size_reg == SIZE_BYTE)
            rd_bytes[31:8] = '0;
        else if (size_reg == SIZE_WORD)
            rd_bytes[31:16] = '0;
    end

    assign rd_line  = rd_addr[ADDR_W-1:LINE_SH];
    assign cur_line = base[ADDR_W-1:LINE_SH];
    assign cur_row  = cur_line[LINE_W-1:VROW_SH];
    assign cur_bit  = cur_line[VROW_SH-1:0];
    assign line_hit = vq_reg[cur_bit];
    assign miss_wr  = cmd.exec && (kind_reg == KIND_CACHE_RD) && !line_hit;

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            vmem[clr_ptr_reg] <= '0;
        else if (miss_wr)
            vmem[cur_row] <= vq_reg | (VROW_BITS'(1) << cur_bit);
        vq_reg <= vmem[rd_line[LINE_W-1:VROW_SH]];
    end

    assign wr_mode = data_reg & DIAG_MODE_MASK;

    always_comb
    begin
        split_next = split_reg;
        ctrl_next  = ctrl_reg;
        diag_next  = diag_reg;
        pend_next  = pend_reg;
        rd_val     = '0;
        case (kind_reg)
            KIND_CACHE_RD:
            begin
                rd_val = rd_bytes;
                if (!line_hit)
                    diag_next = diag_reg | DIAG_MISS;
                else
                    pend_next = 1'b0;
            end
            KIND_STORE_WR:
            begin
                rd_val = '0;
            end
            KIND_REG_RD:
            begin
                if (addr_reg == REG_SPLIT)
                    rd_val = {24'd0, split_reg};
                else if (addr_reg == REG_CTRL)
                    rd_val = {24'd0, ctrl_reg};
                else if (addr_reg == REG_DIAG)
                    rd_val = {24'd0, diag_reg};
                else
                    rd_val = {24'd0, REG_UNKNOWN};
            end
            default:
            begin
                if (addr_reg == REG_SPLIT)
                    split_next = data_reg;
                else if (addr_reg == REG_CTRL)
                    ctrl_next = data_reg;
                else if (addr_reg == REG_DIAG)
                begin
                    diag_next = (diag_reg & DIAG_MISS) | (data_reg & DIAG_WR_MASK);
                    if (data_reg[1])
                    begin
                        diag_next[7] = pend_reg;
                        pend_next    = 1'b0;
                    end
                    if (wr_mode == DIAG_MODE_WIN && (diag_reg & DIAG_MODE_MASK) != DIAG_MODE_WIN)
                        pend_next = 1'b1;
                end
            end
        endcase
    end

    assign sts.clear_req = (kind_reg == KIND_REG_WR) && (addr_reg == REG_DIAG) &&
                           (wr_mode == DIAG_MODE_CLR) &&
                           ((diag_reg & DIAG_MODE_MASK) != DIAG_MODE_CLR);
    assign sts.clear_done = (clr_ptr_reg == VROW_W'(VROWS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_reg   <= '0;
            ctrl_reg    <= CTRL_RESET;
            diag_reg    <= '0;
            pend_reg    <= 1'b0;
            clr_ptr_reg <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                split_reg <= split_next;
                ctrl_reg  <= ctrl_next;
                diag_reg  <= diag_next;
                pend_reg  <= pend_next;
            end
            // wraps back to zero on the last row
            if (cmd.clear_step)
                clr_ptr_reg <= clr_ptr_reg + VROW_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            read_data_reg <= rd_val;
            window_reg    <= ((ctrl_next & CTRL_WIN_EN) != 8'd0) &&
                             ((diag_next & DIAG_MODE_MASK) == DIAG_MODE_WIN);
            rom_reg       <= diag_next[0];
        end
    end

    assign read_data     = read_data_reg;
    assign window_active = window_reg;
    assign rom_timing    = rom_reg;

endmodule
